// ===== rtl/nfapm_pkg.sv =====
// Shared package of the NFA pattern matcher: the request item type, the command
// and sequencer state encodings, and the node kind codes. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nfapm_pkg;

   localparam logic [2:0] OP_WRITE_NODE  = 3'd0;
   localparam logic [2:0] OP_WRITE_RANGE = 3'd1;
   localparam logic [2:0] OP_BEGIN_TEXT  = 3'd2;
   localparam logic [2:0] OP_CODE_POINT  = 3'd3;
   localparam logic [2:0] OP_END_TEXT    = 3'd4;

   localparam logic [2:0] KIND_MATCH = 3'd0;
   localparam logic [2:0] KIND_SPLIT = 3'd1;
   localparam logic [2:0] KIND_JUMP  = 3'd2;
   localparam logic [2:0] KIND_START = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;
   localparam logic [2:0] KIND_CHAR  = 3'd5;

   localparam logic CSR_NODE_COUNT = 1'b0;
   localparam logic CSR_ENTRY_NODE = 1'b1;

   localparam int NODE_WORD  = 23;
   localparam int RANGE_WORD = 42;

   typedef enum logic [2:0] {
      CMD_NODE, CMD_RANGE, CMD_BEGIN, CMD_POINT, CMD_END
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_SWEEP, ST_DRAIN, ST_SETTLE,
      ST_ADV_READ, ST_ADV_NODE, ST_RNG_READ, ST_RNG_CMP, ST_RESP
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [5:0]  node_index;
      logic [2:0]  node_kind;
      logic [7:0]  first_target;
      logic [7:0]  second_target;
      logic [3:0]  range_total;
      logic [2:0]  range_slot;
      logic [20:0] range_low;
      logic [20:0] range_high;
      logic [20:0] code_point;
   } item_type;

   typedef struct packed {
      logic decided;
      logic matched;
      logic bad;
   } flags_type;

endpackage
`default_nettype wire

// ===== rtl/nfapm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the node and range stores; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
module nfapm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/nfapm_front.sv =====
// Front end of the matcher: decodes request opcodes into commands and holds them
// in a two-entry queue for the engine. Depends on nfapm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nfapm_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_op,
   input  wire logic [5:0]        req_node_index,
   input  wire logic [2:0]        req_node_kind,
   input  wire logic [7:0]        req_first_target,
   input  wire logic [7:0]        req_second_target,
   input  wire logic [3:0]        req_range_total,
   input  wire logic [2:0]        req_range_slot,
   input  wire logic [20:0]       req_range_low,
   input  wire logic [20:0]       req_range_high,
   input  wire logic [20:0]       req_code_point,
   output nfapm_pkg::item_type    head,
   output logic                   head_valid,
   input  wire logic              head_pop
);
   import nfapm_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   item;
   logic       cmd_ok, push, pop;

   // Undefined opcodes are accepted and dropped here.
   always_comb begin
      cmd_ok = 1'b1;
      item.cmd = CMD_NODE;
      case (req_op)
         OP_WRITE_NODE:  item.cmd = CMD_NODE;
         OP_WRITE_RANGE: item.cmd = CMD_RANGE;
         OP_BEGIN_TEXT:  item.cmd = CMD_BEGIN;
         OP_CODE_POINT:  item.cmd = CMD_POINT;
         OP_END_TEXT:    item.cmd = CMD_END;
         default:        cmd_ok = 1'b0;
      endcase
      item.node_index    = req_node_index;
      item.node_kind     = req_node_kind;
      item.first_target  = req_first_target;
      item.second_target = req_second_target;
      item.range_total   = req_range_total;
      item.range_slot    = req_range_slot;
      item.range_low     = req_range_low;
      item.range_high    = req_range_high;
      item.code_point    = req_code_point;
   end

   assign req_ready  = (cnt_ff != 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready && cmd_ok;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/nfapm_engine.sv =====
// Back end of the matcher: program stores, epsilon closure sweeps, range scan
// and the result register. Depends on nfapm_pkg and nfapm_ram.
`timescale 1ns / 1ps
`default_nettype none
module nfapm_engine #(
   parameter int NFA_NODES       = 64,
   parameter int RANGES_PER_NODE = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [6:0]           node_count,
   input  wire logic [5:0]           entry_node,
   input  wire nfapm_pkg::item_type  head,
   input  wire logic                 head_valid,
   output logic                      head_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output nfapm_pkg::flags_type      rsp_flags
);
   import nfapm_pkg::*;

   localparam int IW     = $clog2(NFA_NODES);
   localparam int RW     = (RANGES_PER_NODE > 1) ? $clog2(RANGES_PER_NODE) : 1;
   localparam int RDEPTH = NFA_NODES << RW;
   localparam logic [IW-1:0] LAST = IW'(NFA_NODES - 1);

   state_type        state_ff, state_in;
   logic [NFA_NODES-1:0] reached_ff, reached_in, expanded_ff, expanded_in;
   logic [NFA_NODES-1:0] carried_ff, carried_in, next_ff, next_in;
   logic             carried_bad_ff, carried_bad_in, next_bad_ff, next_bad_in;
   logic             bad_ff, bad_in, hit_ff, hit_in, progress_ff, progress_in;
   logic             at_start_ff, at_start_in, at_end_ff, at_end_in;
   logic [20:0]      cp_ff, cp_in;
   flags_type        flags_ff, flags_in, rsp_flags_ff, rsp_flags_in, settled;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]    idx_ff, idx_in, pidx_ff;
   logic             pvalid_ff, pvalid_in;
   logic [RW-1:0]    rng_ff, rng_in;
   logic [5:0]       rng_total_ff, rng_total_in;
   logic [7:0]       target_ff, target_in;

   logic                  node_we, range_we;
   logic [NODE_WORD-1:0]  node_rd;
   logic [RANGE_WORD-1:0] range_rd;
   logic [2:0]            nd_kind;
   logic [7:0]            nd_t1, nd_t2;
   logic [3:0]            nd_cnt;
   logic [5:0]            nd_lim;
   logic [20:0]           r_low, r_high;
   logic                  proc_fire, adv_take, rng_done, rng_hit;

   nfapm_ram #(.WIDTH(NODE_WORD), .DEPTH(NFA_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (IW'(head.node_index)),
      .wr_data ({head.node_kind, head.first_target, head.second_target,
                 head.range_total}),
      .rd_addr (idx_ff),
      .rd_data (node_rd)
   );

   nfapm_ram #(.WIDTH(RANGE_WORD), .DEPTH(RDEPTH)) u_range_ram (
      .clock   (clock),
      .wr_en   (range_we),
      .wr_addr ({IW'(head.node_index), RW'(head.range_slot)}),
      .wr_data ({head.range_low, head.range_high}),
      .rd_addr ({idx_ff, rng_ff}),
      .rd_data (range_rd)
   );

   assign nd_kind = node_rd[22:20];
   assign nd_t1   = node_rd[19:12];
   assign nd_t2   = node_rd[11:4];
   assign nd_cnt  = node_rd[3:0];
   assign nd_lim  = (32'(nd_cnt) > RANGES_PER_NODE) ? 6'(RANGES_PER_NODE) : 6'(nd_cnt);
   assign r_low   = range_rd[41:21];
   assign r_high  = range_rd[20:0];

   assign proc_fire = pvalid_ff && reached_ff[pidx_ff] && !expanded_ff[pidx_ff];
   assign adv_take  = reached_ff[idx_ff] && (nd_kind == KIND_CHAR) && (nd_lim != 6'd0);
   assign rng_hit   = (cp_ff >= r_low) && (cp_ff <= r_high);
   assign rng_done  = (cp_ff < r_low) || rng_hit || (32'(rng_ff) + 1 >= 32'(rng_total_ff));

   always_comb begin
      settled = flags_ff;
      if (bad_ff) begin
         settled = '{decided: 1'b1, matched: 1'b0, bad: 1'b1};
      end else if (hit_ff) begin
         settled = '{decided: 1'b1, matched: 1'b1, bad: 1'b0};
      end
      if (at_end_ff) begin
         settled.decided = 1'b1;
      end
   end

   assign head_pop  = (state_ff == ST_IDLE) && head_valid;
   assign node_we   = head_pop && (head.cmd == CMD_NODE) && (32'(head.node_index) < NFA_NODES);
   assign range_we  = head_pop && (head.cmd == CMD_RANGE)
                      && (32'(head.node_index) < NFA_NODES)
                      && (32'(head.range_slot) < RANGES_PER_NODE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_flags = rsp_flags_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid && (head.cmd == CMD_POINT || head.cmd == CMD_END)) begin
               state_in = flags_ff.decided ? ST_RESP : ST_INIT;
            end
         end
         ST_INIT:   state_in = ST_SWEEP;
         ST_SWEEP:  state_in = (idx_ff == LAST) ? ST_DRAIN : ST_SWEEP;
         ST_DRAIN:  state_in = (progress_ff || proc_fire) ? ST_SWEEP : ST_SETTLE;
         ST_SETTLE: state_in = settled.decided ? ST_RESP : ST_ADV_READ;
         ST_ADV_READ: state_in = ST_ADV_NODE;
         ST_ADV_NODE: begin
            if (adv_take) begin
               state_in = ST_RNG_READ;
            end else begin
               state_in = (idx_ff == LAST) ? ST_RESP : ST_ADV_READ;
            end
         end
         ST_RNG_READ: state_in = ST_RNG_CMP;
         ST_RNG_CMP: begin
            if (!rng_done) begin
               state_in = ST_RNG_READ;
            end else begin
               state_in = (idx_ff == LAST) ? ST_RESP : ST_ADV_READ;
            end
         end
         ST_RESP: state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_RESP;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      reached_in     = reached_ff;
      expanded_in    = expanded_ff;
      carried_in     = carried_ff;
      carried_bad_in = carried_bad_ff;
      next_in        = next_ff;
      next_bad_in    = next_bad_ff;
      bad_in         = bad_ff;
      hit_in         = hit_ff;
      progress_in    = progress_ff;
      at_start_in    = at_start_ff;
      at_end_in      = at_end_ff;
      cp_in          = cp_ff;
      flags_in       = flags_ff;
      rsp_flags_in   = rsp_flags_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      idx_in         = idx_ff;
      pvalid_in      = (state_ff == ST_SWEEP);
      rng_in         = rng_ff;
      rng_total_in   = rng_total_ff;
      target_in      = target_ff;

      // Expansion of the node read in the previous sweep cycle.
      if (proc_fire) begin
         expanded_in[pidx_ff] = 1'b1;
         progress_in = 1'b1;
         if (nd_kind == KIND_MATCH) begin
            hit_in = 1'b1;
         end
         if (nd_kind == KIND_SPLIT || nd_kind == KIND_JUMP
             || (nd_kind == KIND_START && at_start_ff)
             || (nd_kind == KIND_END && at_end_ff)) begin
            if ({1'b0, nd_t1} >= {1'b0, node_count} || 32'(nd_t1) >= NFA_NODES) begin
               bad_in = 1'b1;
            end else begin
               reached_in[IW'(nd_t1)] = 1'b1;
            end
         end
         if (nd_kind == KIND_SPLIT) begin
            if ({1'b0, nd_t2} >= {1'b0, node_count} || 32'(nd_t2) >= NFA_NODES) begin
               bad_in = 1'b1;
            end else begin
               reached_in[IW'(nd_t2)] = 1'b1;
            end
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               case (head.cmd)
                  CMD_BEGIN: begin
                     carried_in     = '0;
                     carried_bad_in = 1'b0;
                     at_start_in    = 1'b1;
                     flags_in       = '0;
                  end
                  CMD_POINT, CMD_END: begin
                     cp_in     = head.code_point;
                     at_end_in = (head.cmd == CMD_END);
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            reached_in  = '0;
            expanded_in = '0;
            hit_in      = 1'b0;
            progress_in = 1'b0;
            idx_in      = '0;
            bad_in      = carried_bad_ff;
            for (int i = 0; i < NFA_NODES; i++) begin
               if (carried_ff[i]) begin
                  if (i >= 32'(node_count)) begin
                     bad_in = 1'b1;
                  end else begin
                     reached_in[i] = 1'b1;
                  end
               end
            end
            if ({1'b0, entry_node} >= node_count || 32'(entry_node) >= NFA_NODES) begin
               bad_in = 1'b1;
            end else begin
               reached_in[IW'(entry_node)] = 1'b1;
            end
         end
         ST_SWEEP: begin
            idx_in = idx_ff + 1'b1;
         end
         ST_DRAIN: begin
            idx_in      = '0;
            progress_in = 1'b0;
         end
         ST_SETTLE: begin
            flags_in    = settled;
            idx_in      = '0;
            next_in     = '0;
            next_bad_in = 1'b0;
         end
         ST_ADV_NODE: begin
            if (adv_take) begin
               target_in    = nd_t1;
               rng_total_in = nd_lim;
               rng_in       = '0;
            end else if (idx_ff == LAST) begin
               carried_in     = next_ff;
               carried_bad_in = next_bad_ff;
               at_start_in    = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RNG_CMP: begin
            if (rng_hit && !(cp_ff < r_low)) begin
               if (32'(target_ff) < NFA_NODES) begin
                  next_in[IW'(target_ff)] = 1'b1;
               end else begin
                  next_bad_in = 1'b1;
               end
            end
            if (!rng_done) begin
               rng_in = rng_ff + 1'b1;
            end else if (idx_ff == LAST) begin
               carried_in     = next_in;
               carried_bad_in = next_bad_in;
               at_start_in    = 1'b0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_flags_in = flags_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      reached_ff   <= reached_in;
      expanded_ff  <= expanded_in;
      next_ff      <= next_in;
      next_bad_ff  <= next_bad_in;
      bad_ff       <= bad_in;
      hit_ff       <= hit_in;
      progress_ff  <= progress_in;
      at_end_ff    <= at_end_in;
      cp_ff        <= cp_in;
      rsp_flags_ff <= rsp_flags_in;
      idx_ff       <= idx_in;
      pidx_ff      <= idx_ff;
      rng_ff       <= rng_in;
      rng_total_ff <= rng_total_in;
      target_ff    <= target_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         carried_ff     <= '0;
         carried_bad_ff <= 1'b0;
         at_start_ff    <= 1'b1;
         flags_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         pvalid_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         carried_ff     <= carried_in;
         carried_bad_ff <= carried_bad_in;
         at_start_ff    <= at_start_in;
         flags_ff       <= flags_in;
         rsp_valid_ff   <= rsp_valid_in;
         pvalid_ff      <= pvalid_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/nfa_pattern_matcher_unit.sv =====
// Top level of the NFA pattern matcher: configuration registers, front queue
// and match engine. Depends on nfapm_pkg, nfapm_front and nfapm_engine.
`timescale 1ns / 1ps
`default_nettype none
// Unanchored NFA regex search over a stream of code points. Requests with op 0
// and 1 load node and range entries, op 2 starts a text, op 3 feeds one code
// point and op 4 ends the text; ops 3 and 4 each return one response carrying
// decided, matched and bad_state. Requests are decoded into a two-entry queue,
// so the caller can post the next request while the engine works. A code
// point or end request costs the epsilon closure, which sweeps the node store
// one node per cycle and repeats the sweep until one expands no node; the
// engine also takes the request, seeds the closure, settles the outcome and
// loads the response, and for a code point that does not decide it then scans
// the ranges of each reached character node. A request that arrives after the
// outcome is decided skips the closure and goes straight to the response. A
// response is held in its own register until taken, and the engine waits
// there only when that register is full.
module nfa_pattern_matcher_unit #(
   parameter int NFA_NODES       = 64,
   parameter int RANGES_PER_NODE = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [5:0]  req_node_index,
   input  wire logic [2:0]  req_node_kind,
   input  wire logic [7:0]  req_first_target,
   input  wire logic [7:0]  req_second_target,
   input  wire logic [3:0]  req_range_total,
   input  wire logic [2:0]  req_range_slot,
   input  wire logic [20:0] req_range_low,
   input  wire logic [20:0] req_range_high,
   input  wire logic [20:0] req_code_point,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_decided,
   output logic             rsp_matched,
   output logic             rsp_bad_state,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_write_data
);
   import nfapm_pkg::*;

   logic [6:0] node_count_ff, node_count_in;
   logic [5:0] entry_node_ff, entry_node_in;
   item_type   head;
   logic       head_valid, head_pop;
   flags_type  flags;

   // Configuration must only be written while the block is idle; the block itself does not enforce this.
   always_comb begin
      node_count_in = node_count_ff;
      entry_node_in = entry_node_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_in = csr_write_data;
            CSR_ENTRY_NODE: entry_node_in = csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 7'd1;
         entry_node_ff <= 6'd0;
      end else begin
         node_count_ff <= node_count_in;
         entry_node_ff <= entry_node_in;
      end
   end

   nfapm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_node_index    (req_node_index),
      .req_node_kind     (req_node_kind),
      .req_first_target  (req_first_target),
      .req_second_target (req_second_target),
      .req_range_total   (req_range_total),
      .req_range_slot    (req_range_slot),
      .req_range_low     (req_range_low),
      .req_range_high    (req_range_high),
      .req_code_point    (req_code_point),
      .head              (head),
      .head_valid        (head_valid),
      .head_pop          (head_pop)
   );

   nfapm_engine #(
      .NFA_NODES       (NFA_NODES),
      .RANGES_PER_NODE (RANGES_PER_NODE)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .node_count (node_count_ff),
      .entry_node (entry_node_ff),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_flags  (flags)
   );

   assign rsp_decided   = flags.decided;
   assign rsp_matched   = flags.matched;
   assign rsp_bad_state = flags.bad;
endmodule
`default_nettype wire
